[rtl/csev_pkg.sv]
// csev_pkg: shared constants, codes, control structs and the saturate helper
// for the Chebyshev series evaluator. No dependencies.

package csev_pkg;

  localparam int MAX_ORDER   = 15;
  localparam int VALUE_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int VW          = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ORD_W       = $clog2(MAX_ORDER + 1);
  localparam int BIDX_W      = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int POLY_W      = 4;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SERIES = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BASIS  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE  = 2'd2;

  localparam logic signed [DATA_W-1:0] SCALE_RST = 32'sd16777216;  // 1.0 in Q8.24
  localparam logic signed [DATA_W-1:0] ONE_Q30   = 32'sd1073741824; // 1.0 in Q2.30

  typedef struct packed {
    logic             capture;    // item accepted, latch x
    logic             coef_we;    // load item: write table
    logic             series;     // run is a series evaluation
    logic             aff_mul;    // scale * x
    logic             aff_add;    // round, add offset, saturate -> u
    logic             step_mul;   // u * b1, table read
    logic             step_acc;   // round, subtract b2, add coefficient when use_coef
    logic             use_coef;
    logic             final_step; // Clenshaw closing step, shift by 30
    logic [ORD_W-1:0] rd_addr;
    logic             emit;
    logic             emit_one;
    logic             emit_last;
    logic [ORD_W-1:0] emit_idx;
  } csev_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [ORD_W-1:0] order;      // min(poly_order, MAX_ORDER)
  } csev_sts_t;

  // Clip v to w-bit signed; returns {clipped, value sign-extended to DATA_W}.
  function automatic logic [DATA_W:0] sat_to(input logic signed [PROD_W-1:0] v,
                                               input int unsigned w);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = (PROD_W'(64'sd1) <<< (w - 1)) - PROD_W'(64'sd1);
    lo = -(PROD_W'(64'sd1) <<< (w - 1));
    if (v > hi) begin
      return {1'b1, hi[DATA_W-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[DATA_W-1:0]};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

endpackage

[rtl/csev_ifs.sv]
// Channel interfaces of the Chebyshev series evaluator: input items,
// result items and configuration writes. Depends on csev_pkg.

interface csev_in_if import csev_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [BIDX_W-1:0]        coef_index;
  logic signed [DATA_W-1:0] coef_value;
  logic signed [DATA_W-1:0] x_value;
  modport source (output valid, mode, coef_index, coef_value, x_value, input ready);
  modport sink   (input valid, mode, coef_index, coef_value, x_value, output ready);
endinterface

interface csev_out_if import csev_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [BIDX_W-1:0]        basis_index;
  logic                     last_of_run;
  logic                     saturated;
  modport source (output valid, result_value, basis_index, last_of_run, saturated,
                  input ready);
  modport sink   (input valid, result_value, basis_index, last_of_run, saturated,
                  output ready);
endinterface

interface csev_cfg_if import csev_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/chebyshev_series_evaluator.sv]
// chebyshev_series_evaluator: top level; joins the sequencer and datapath
// to the channel interfaces. Depends on csev_pkg, csev_ifs, csev_ctrl, csev_dpath.

// Evaluates a Chebyshev series of order n = min(poly_order, 15) by the Clenshaw
// recurrence, or streams the basis values T0..Tn, at x mapped as
// u = range_offset + range_scale * x (u in Q2.30, values Q16.16). Load items
// (mode 0) write one coefficient; mode 3 items are dropped.
// Everything runs through a single 32x32 multiplier with a register after it,
// so each recurrence step is a multiply followed by a round and add.
// A basis item gives one result per order. Either kind waits in its emit
// state whenever the result register is still occupied. One item is
// worked at a time: the input is ready only while the sequencer is idle,
// but a finished result may sit in the output register while the next
// item is accepted.
// Configuration writes are always taken and must be made while idle.
// Coefficients must be loaded before they are used.

module chebyshev_series_evaluator import csev_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  csev_in_if.sink       in_if,
  csev_out_if.source    out_if,
  csev_cfg_if.sink      cfg_if
);

  csev_cmd_t cmd;
  csev_sts_t sts;
  logic      in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;   // registers take a write in any cycle

  csev_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csev_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_coef_index    (in_if.coef_index),
    .in_coef_value    (in_if.coef_value),
    .in_x_value       (in_if.x_value),
    .cfg_we           (cfg_if.valid),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_result_value (out_if.result_value),
    .out_basis_index  (out_if.basis_index),
    .out_last_of_run  (out_if.last_of_run),
    .out_saturated    (out_if.saturated)
  );

endmodule

[rtl/csev_ctrl.sv]
// csev_ctrl: sequencer for the evaluator; issues datapath commands per step.
// Depends on csev_pkg.

module csev_ctrl import csev_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  csev_sts_t         sts,
  output csev_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_AFF_MUL  = 3'd1;
  localparam logic [2:0] S_AFF_ADD  = 3'd2;
  localparam logic [2:0] S_STEP_MUL = 3'd3;
  localparam logic [2:0] S_STEP_ACC = 3'd4;
  localparam logic [2:0] S_FIN_MUL  = 3'd5;
  localparam logic [2:0] S_FIN_ACC  = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [ORD_W-1:0] j_r, j_nxt;
  logic             series_r, series_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    series_nxt = series_r;
    cmd        = '0;
    cmd.series = series_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.coef_we = (in_mode == MODE_LOAD);
          if (in_mode == MODE_SERIES || in_mode == MODE_BASIS) begin
            series_nxt = (in_mode == MODE_SERIES);
            j_nxt      = (in_mode == MODE_SERIES) ? sts.order : '0;
            state_nxt  = S_AFF_MUL;
          end
        end
      end
      S_AFF_MUL: begin
        cmd.aff_mul = 1'b1;
        state_nxt   = S_AFF_ADD;
      end
      S_AFF_ADD: begin
        cmd.aff_add = 1'b1;
        if (!series_r) begin
          state_nxt = S_EMIT;
        end else if (j_r == '0) begin
          state_nxt = S_FIN_MUL;
        end else begin
          state_nxt = S_STEP_MUL;
        end
      end
      S_STEP_MUL: begin
        cmd.step_mul = 1'b1;
        cmd.rd_addr  = j_r;
        state_nxt    = S_STEP_ACC;
      end
      S_STEP_ACC: begin
        cmd.step_acc = 1'b1;
        cmd.use_coef = series_r;
        if (!series_r) begin
          state_nxt = S_EMIT;
        end else if (j_r == ORD_W'(1)) begin
          state_nxt = S_FIN_MUL;
        end else begin
          j_nxt     = j_r - ORD_W'(1);
          state_nxt = S_STEP_MUL;
        end
      end
      S_FIN_MUL: begin
        cmd.step_mul = 1'b1;
        cmd.rd_addr  = '0;
        state_nxt    = S_FIN_ACC;
      end
      S_FIN_ACC: begin
        cmd.step_acc   = 1'b1;
        cmd.use_coef   = 1'b1;
        cmd.final_step = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_one  = !series_r && (j_r == '0);
        cmd.emit_idx  = series_r ? '0 : j_r;
        cmd.emit_last = series_r || (j_r == sts.order);
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.emit_last) begin
            state_nxt = S_IDLE;
          end else if (j_r == '0) begin
            j_nxt = ORD_W'(1);          // T1 = u already sits in b1
          end else begin
            j_nxt     = j_r + ORD_W'(1);
            state_nxt = S_STEP_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      j_r      <= '0;
      series_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      j_r      <= j_nxt;
      series_r <= series_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result written into an occupied output slot");

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (j_r <= sts.order))
    else $error("order counter beyond the configured order");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> (state_r == S_IDLE))
    else $error("run continued after its last result");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_acc |-> ($past(state_r) == S_STEP_MUL || $past(state_r) == S_FIN_MUL))
    else $error("accumulate step without a product");
`endif

endmodule

[rtl/csev_dpath.sv]
// csev_dpath: configuration registers, coefficient table, shared multiplier,
// round/saturate accumulator and result register. Depends on csev_pkg.

module csev_dpath import csev_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csev_cmd_t                cmd,
  output csev_sts_t                sts,
  input  logic [BIDX_W-1:0]        in_coef_index,
  input  logic signed [DATA_W-1:0] in_coef_value,
  input  logic signed [DATA_W-1:0] in_x_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [BIDX_W-1:0]        out_basis_index,
  output logic                     out_last_of_run,
  output logic                     out_saturated
);

  localparam logic signed [PROD_W-1:0] HALF10 = PROD_W'(64'sd512);
  localparam logic signed [PROD_W-1:0] HALF29 = PROD_W'(64'sd268435456);
  localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(64'sd536870912);

  logic [POLY_W-1:0]        poly_order_r;
  logic signed [DATA_W-1:0] range_offset_r;
  logic signed [DATA_W-1:0] range_scale_r;

  logic signed [DATA_W-1:0] coef_mem [0:MAX_ORDER];
  logic signed [DATA_W-1:0] coef_q_r;

  logic signed [DATA_W-1:0] x_r, u_r, b1_r, b2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     sat_r;

  logic signed [DATA_W-1:0] out_value_r;
  logic [BIDX_W-1:0]        out_idx_r;
  logic                     out_last_r, out_sat_r, out_valid_r;

  logic signed [DATA_W-1:0] mul_a, mul_b, addend;
  logic signed [PROD_W-1:0] prod_nxt, aff_sum, acc_rnd, acc_sum;
  logic [DATA_W:0]          aff_sat, acc_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_order_r   <= '0;
      range_offset_r <= '0;
      range_scale_r  <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLY_ORDER:   poly_order_r   <= cfg_data[POLY_W-1:0];
        REG_RANGE_OFFSET: range_offset_r <= cfg_data;
        REG_RANGE_SCALE:  range_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sts.order = (int'(poly_order_r) > MAX_ORDER) ? ORD_W'(MAX_ORDER)
                                                      : ORD_W'(poly_order_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // coefficient table, registered read
  always_ff @(posedge clk) begin
    if (cmd.coef_we && (int'(in_coef_index) <= MAX_ORDER)) begin
      coef_mem[ORD_W'(in_coef_index)] <= in_coef_value;
    end
    if (cmd.step_mul) begin
      coef_q_r <= coef_mem[cmd.rd_addr];
    end
  end

  // one shared multiplier
  assign mul_a    = cmd.aff_mul ? range_scale_r : u_r;
  assign mul_b    = cmd.aff_mul ? x_r : b1_r;
  assign prod_nxt = mul_a * mul_b;

  // u = sat32(round(scale*x >> 10) + offset << 14)
  assign aff_sum = ((prod_r + HALF10) >>> 10) + (PROD_W'(range_offset_r) <<< 14);
  assign aff_sat = sat_to(aff_sum, DATA_W);

  // b = sat(round(u*b1 >> s) - b2 + c)
  assign addend  = cmd.use_coef ? coef_q_r : '0;
  assign acc_rnd = cmd.final_step ? ((prod_r + HALF30) >>> 30)
                                  : ((prod_r + HALF29) >>> 29);
  assign acc_sum = acc_rnd - PROD_W'(b2_r) + PROD_W'(addend);
  assign acc_sat = sat_to(acc_sum, cmd.use_coef ? VW : DATA_W);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= in_x_value;
    end
    if (cmd.aff_mul || cmd.step_mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.aff_add) begin
      u_r   <= aff_sat[DATA_W-1:0];
      sat_r <= aff_sat[DATA_W];
      if (cmd.series) begin
        b1_r <= '0;
        b2_r <= '0;
      end else begin
        b1_r <= aff_sat[DATA_W-1:0];
        b2_r <= ONE_Q30;
      end
    end
    if (cmd.step_acc) begin
      b1_r  <= acc_sat[DATA_W-1:0];
      b2_r  <= b1_r;
      sat_r <= sat_r | acc_sat[DATA_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= cmd.emit_one ? ONE_Q30 : b1_r;
      out_idx_r   <= BIDX_W'(cmd.emit_idx);
      out_last_r  <= cmd.emit_last;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_basis_index  = out_idx_r;
  assign out_last_of_run  = out_last_r;
  assign out_saturated    = out_sat_r;

endmodule
